>>> src/lsv_pkg.sv
// ----------------------------------------------------------------------------
// lsv_pkg
// Shared constants, codes and controller/datapath link types of the sampler
// voice.
// ----------------------------------------------------------------------------
package lsv_pkg;

	localparam int ADDR_BITS   = 20;
	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 16;

	localparam int POS_W    = ADDR_BITS + FRAC_BITS;
	localparam int IDX_W    = ADDR_BITS + 1;
	localparam int SUM_W    = ADDR_BITS + 2;
	localparam int RECIP_W  = 17;
	localparam int PITCH_W  = 18;
	localparam int STEP_W   = 2 * PITCH_W - (32 - FRAC_BITS);
	localparam int BLEND_W  = SAMPLE_BITS + 19;
	localparam int INTERP_W = SAMPLE_BITS + FRAC_BITS + 3;

	localparam logic [RECIP_W-1:0]   W_ONE      = RECIP_W'(65536);
	localparam logic [BLEND_W-1:0]   BLEND_HALF = BLEND_W'(32768);
	localparam logic [FRAC_BITS:0]   F_ONE      = (FRAC_BITS + 1)'(1) << FRAC_BITS;
	localparam logic [INTERP_W-1:0]  F_HALF     = INTERP_W'(1) << (FRAC_BITS - 1);

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = IDX_W;

	// Item kinds carried in tuser.
	localparam logic [1:0] FN_WRITE   = 2'd0;
	localparam logic [1:0] FN_TICK    = 2'd1;
	localparam logic [1:0] FN_RESTART = 2'd2;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_END_SAMPLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_START = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_END   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_XF_LEN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_XF_RECIP   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_EN    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_PITCH = 3'd6;

	// Kind of sample fetch.
	localparam logic [1:0] KIND_PLAIN = 2'd0;
	localparam logic [1:0] KIND_XF    = 2'd1;
	localparam logic [1:0] KIND_ZERO  = 2'd2;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_WRITE,
		OP_RESTART,
		OP_XS,
		OP_ENTRY,
		OP_EXIT,
		OP_END,
		OP_FSET,
		OP_FRD1,
		OP_FRD2,
		OP_FMIX,
		OP_INT1,
		OP_INT2,
		OP_STEP,
		OP_ADV,
		OP_ENDCHK,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic tgt_b;
		logic capture;
	} cmd_t;

	typedef struct packed {
		logic alive;
		logic past_end;
		logic blend;
		logic out_free;
	} stat_t;

endpackage

>>> src/lsv_ctrl.sv
// ----------------------------------------------------------------------------
// lsv_ctrl
// Sequencer of the sampler voice: steps each item through the datapath.
// ----------------------------------------------------------------------------
module lsv_ctrl import lsv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [1:0] func,
	input  stat_t      st,
	output cmd_t       cmd
);

	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_WRITE   = 5'd1;
	localparam logic [4:0] ST_RESTART = 5'd2;
	localparam logic [4:0] ST_XS      = 5'd3;
	localparam logic [4:0] ST_ENTRY   = 5'd4;
	localparam logic [4:0] ST_EXIT    = 5'd5;
	localparam logic [4:0] ST_END     = 5'd6;
	localparam logic [4:0] ST_FSET    = 5'd7;
	localparam logic [4:0] ST_FRD1    = 5'd8;
	localparam logic [4:0] ST_FRD2    = 5'd9;
	localparam logic [4:0] ST_FMIX    = 5'd10;
	localparam logic [4:0] ST_INT1    = 5'd11;
	localparam logic [4:0] ST_INT2    = 5'd12;
	localparam logic [4:0] ST_STEP    = 5'd13;
	localparam logic [4:0] ST_ADV     = 5'd14;
	localparam logic [4:0] ST_ENDCHK  = 5'd15;
	localparam logic [4:0] ST_OUT     = 5'd16;

	logic [4:0] state_q, state_d;
	logic       tgt_b_q, tgt_b_d;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d     = state_q;
		tgt_b_d     = tgt_b_q;
		cmd.op      = OP_NONE;
		cmd.tgt_b   = tgt_b_q;
		cmd.capture = accept;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (func == FN_WRITE) state_d = ST_WRITE;
					else if (func == FN_RESTART) state_d = ST_RESTART;
					else if (func == FN_TICK) state_d = ST_XS;
					else state_d = ST_IDLE;
				end
			end
			ST_WRITE: begin
				cmd.op  = OP_WRITE;
				state_d = ST_IDLE;
			end
			ST_RESTART: begin
				cmd.op  = OP_RESTART;
				state_d = ST_IDLE;
			end
			ST_XS: begin
				cmd.op  = OP_XS;
				state_d = st.alive ? ST_ENTRY : ST_OUT;
			end
			ST_ENTRY: begin
				cmd.op  = OP_ENTRY;
				state_d = ST_EXIT;
			end
			ST_EXIT: begin
				cmd.op  = OP_EXIT;
				state_d = ST_END;
			end
			ST_END: begin
				cmd.op  = OP_END;
				tgt_b_d = 1'b0;
				state_d = st.past_end ? ST_OUT : ST_FSET;
			end
			ST_FSET: begin
				cmd.op  = OP_FSET;
				state_d = ST_FRD1;
			end
			ST_FRD1: begin
				cmd.op  = OP_FRD1;
				state_d = ST_FRD2;
			end
			ST_FRD2: begin
				cmd.op = OP_FRD2;
				if (st.blend) begin
					state_d = ST_FMIX;
				end else if (tgt_b_q) begin
					state_d = ST_INT1;
				end else begin
					tgt_b_d = 1'b1;
					state_d = ST_FSET;
				end
			end
			ST_FMIX: begin
				cmd.op = OP_FMIX;
				if (tgt_b_q) begin
					state_d = ST_INT1;
				end else begin
					tgt_b_d = 1'b1;
					state_d = ST_FSET;
				end
			end
			ST_INT1: begin
				cmd.op  = OP_INT1;
				state_d = ST_INT2;
			end
			ST_INT2: begin
				cmd.op  = OP_INT2;
				state_d = ST_STEP;
			end
			ST_STEP: begin
				cmd.op  = OP_STEP;
				state_d = ST_ADV;
			end
			ST_ADV: begin
				cmd.op  = OP_ADV;
				state_d = ST_ENDCHK;
			end
			ST_ENDCHK: begin
				cmd.op  = OP_ENDCHK;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (st.out_free) begin
					cmd.op  = OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tgt_b_q <= 1'b0;
		end else begin
			state_q <= state_d;
			tgt_b_q <= tgt_b_d;
		end
	end

endmodule

>>> src/lsv_dp.sv
// ----------------------------------------------------------------------------
// lsv_dp
// Datapath of the sampler voice: sample RAM, configuration, read position,
// crossfade blend, interpolation and result register.
// ----------------------------------------------------------------------------
module lsv_dp import lsv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output stat_t                 st,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	logic [SAMPLE_BITS-1:0] mem [2**ADDR_BITS];
	logic [SAMPLE_BITS-1:0] mem_q;
	logic [ADDR_BITS-1:0]   rd_idx;

	// Configuration.
	logic [IDX_W-1:0]     end_q, loop_end_q;
	logic [ADDR_BITS-1:0] loop_start_q, xf_len_q;
	logic [RECIP_W-1:0]   xf_recip_q;
	logic                 loop_en_q;
	logic [PITCH_W-1:0]   base_pitch_q;

	// Captured item.
	logic [ADDR_BITS-1:0]          addr_q;
	logic signed [SAMPLE_BITS-1:0] wval_q;
	logic                          sustain_q;
	logic [PITCH_W-1:0]            bend_q;

	// Voice state.
	logic [POS_W-1:0] pos_q;
	logic             xf_q, alive_q, zero_q;
	logic [IDX_W-1:0] xs_q;

	// Fetch and arithmetic registers.
	logic [IDX_W-1:0]              j_q;
	logic [1:0]                    kind_q;
	logic                          blend_q, oob1_q, oob2_q;
	logic [RECIP_W-1:0]            w_q;
	logic signed [BLEND_W-1:0]     bacc_q;
	logic signed [SAMPLE_BITS-1:0] a_q, b_q, s_q;
	logic signed [INTERP_W-1:0]    iacc_q;
	logic [STEP_W-1:0]             step_q;
	logic                          mv_q;
	logic [OUT_DATA_W-1:0]         md_q;

	logic                          looping;
	logic [ADDR_BITS-1:0]          idx;
	logic [FRAC_BITS-1:0]          frac;
	logic [IDX_W-1:0]              idx_p1;
	logic                          past_end;
	logic [SUM_W-1:0]              addr1, addr2;
	logic [IDX_W+RECIP_W-1:0]      wprod;
	logic [RECIP_W-1:0]            w_sat;
	logic signed [SAMPLE_BITS-1:0] v1, v2, vmix, s_new;
	logic signed [BLEND_W-1:0]     bsum;
	logic signed [INTERP_W-1:0]    isum;
	logic [2*PITCH_W-1:0]          sprod;
	logic [POS_W:0]                np_adv;
	logic [ADDR_BITS:0]            np_exit;

	assign looping  = sustain_q && loop_en_q;
	assign idx      = pos_q[POS_W-1:FRAC_BITS];
	assign frac     = pos_q[FRAC_BITS-1:0];
	assign idx_p1   = {1'b0, idx} + IDX_W'(1);
	assign past_end = !looping && !xf_q && ({1'b0, idx} >= end_q);

	assign addr1 = (kind_q == KIND_XF) ? (SUM_W'(loop_start_q) + SUM_W'(j_q)) : SUM_W'(j_q);
	assign addr2 = SUM_W'(xs_q) + SUM_W'(j_q);
	assign wprod = IDX_W'(j_q) * xf_recip_q;
	assign w_sat = (wprod > (IDX_W + RECIP_W)'(W_ONE)) ? W_ONE : wprod[RECIP_W-1:0];

	assign v1    = oob1_q ? '0 : $signed(mem_q);
	assign v2    = oob2_q ? '0 : $signed(mem_q);
	assign bsum  = bacc_q + BLEND_W'(v2) * $signed(BLEND_W'(W_ONE - w_q)) + $signed(BLEND_HALF);
	assign vmix  = bsum[SAMPLE_BITS+15:16];
	assign isum  = iacc_q + INTERP_W'(b_q) * $signed(INTERP_W'(frac)) + $signed(F_HALF);
	assign s_new = isum[FRAC_BITS+SAMPLE_BITS-1:FRAC_BITS];
	assign sprod = base_pitch_q * bend_q;
	assign np_adv  = {1'b0, pos_q} + (POS_W + 1)'(step_q);
	assign np_exit = {1'b0, idx} + {1'b0, loop_start_q};

	assign rd_idx = (cmd.op == OP_FRD2) ? addr2[ADDR_BITS-1:0] : addr1[ADDR_BITS-1:0];

	assign st.alive    = alive_q;
	assign st.past_end = past_end;
	assign st.blend    = blend_q;
	assign st.out_free = !mv_q || m_tready;

	assign m_tvalid = mv_q;
	assign m_tdata  = md_q;

	always_ff @(posedge clk) begin
		if (cmd.op == OP_WRITE) begin
			mem[addr_q] <= wval_q;
		end
		mem_q <= mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_q        <= '0;
			loop_start_q <= '0;
			loop_end_q   <= '0;
			xf_len_q     <= '0;
			xf_recip_q   <= '0;
			loop_en_q    <= 1'b0;
			base_pitch_q <= PITCH_W'(65536);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_END_SAMPLE: end_q        <= cfg_data;
				REG_LOOP_START: loop_start_q <= cfg_data[ADDR_BITS-1:0];
				REG_LOOP_END:   loop_end_q   <= cfg_data;
				REG_XF_LEN:     xf_len_q     <= cfg_data[ADDR_BITS-1:0];
				REG_XF_RECIP:   xf_recip_q   <= cfg_data[RECIP_W-1:0];
				REG_LOOP_EN:    loop_en_q    <= cfg_data[0];
				REG_BASE_PITCH: base_pitch_q <= cfg_data[PITCH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q    <= s_tdata[19:0];
			wval_q    <= s_tdata[35:20];
			sustain_q <= s_tdata[36];
			bend_q    <= s_tdata[54:37];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			xf_q    <= 1'b0;
			alive_q <= 1'b1;
			zero_q  <= 1'b0;
			mv_q    <= 1'b0;
			blend_q <= 1'b0;
		end else begin
			if (cmd.op == OP_OUT) begin
				mv_q <= 1'b1;
			end else if (m_tready) begin
				mv_q <= 1'b0;
			end
			unique case (cmd.op)
				OP_RESTART: begin
					pos_q   <= {addr_q, {FRAC_BITS{1'b0}}};
					xf_q    <= 1'b0;
					alive_q <= 1'b1;
				end
				OP_XS: begin
					zero_q <= !alive_q;
				end
				OP_ENTRY: begin
					if (!xf_q && looping && ({1'b0, idx} >= xs_q)) begin
						xf_q                      <= 1'b1;
						pos_q[POS_W-1:FRAC_BITS] <= idx - xs_q[ADDR_BITS-1:0];
					end
				end
				OP_EXIT: begin
					if (xf_q && (idx >= xf_len_q)) begin
						xf_q <= 1'b0;
						if (np_exit[ADDR_BITS]) begin
							pos_q <= '1;
						end else begin
							pos_q[POS_W-1:FRAC_BITS] <= np_exit[ADDR_BITS-1:0];
						end
					end
				end
				OP_END: begin
					if (past_end) begin
						alive_q <= 1'b0;
						zero_q  <= 1'b1;
					end
				end
				OP_FRD1: begin
					blend_q <= (kind_q == KIND_XF) && (j_q < {1'b0, xf_len_q});
				end
				OP_FRD2: begin
				end
				OP_ADV: begin
					if (np_adv[POS_W]) begin
						pos_q <= '1;
						if (!looping && !xf_q) begin
							alive_q <= 1'b0;
						end
					end else begin
						pos_q <= np_adv[POS_W-1:0];
					end
				end
				OP_ENDCHK: begin
					if (past_end) begin
						alive_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_XS) begin
			xs_q <= ({1'b0, xf_len_q} > loop_end_q) ? '0 : loop_end_q - {1'b0, xf_len_q};
		end
		if (cmd.op == OP_FSET) begin
			if (!cmd.tgt_b) begin
				j_q    <= {1'b0, idx};
				kind_q <= xf_q ? KIND_XF : KIND_PLAIN;
			end else begin
				priority if (xf_q) begin
					j_q    <= idx_p1;
					kind_q <= KIND_XF;
				end else if (looping && (idx_p1 == xs_q)) begin
					j_q    <= '0;
					kind_q <= KIND_XF;
				end else if (!looping && (idx_p1 >= end_q)) begin
					j_q    <= idx_p1;
					kind_q <= KIND_ZERO;
				end else begin
					j_q    <= idx_p1;
					kind_q <= KIND_PLAIN;
				end
			end
		end
		if (cmd.op == OP_FRD1) begin
			w_q    <= w_sat;
			oob1_q <= (kind_q == KIND_ZERO) || (addr1[SUM_W-1:ADDR_BITS] != '0);
		end
		if (cmd.op == OP_FRD2) begin
			oob2_q <= (addr2[SUM_W-1:ADDR_BITS] != '0);
			if (blend_q) begin
				bacc_q <= BLEND_W'(v1) * $signed(BLEND_W'(w_q));
			end else if (cmd.tgt_b) begin
				b_q <= v1;
			end else begin
				a_q <= v1;
			end
		end
		if (cmd.op == OP_FMIX) begin
			if (cmd.tgt_b) begin
				b_q <= vmix;
			end else begin
				a_q <= vmix;
			end
		end
		if (cmd.op == OP_INT1) begin
			iacc_q <= INTERP_W'(a_q) * $signed(INTERP_W'(F_ONE - {1'b0, frac}));
		end
		if (cmd.op == OP_INT2) begin
			s_q <= s_new;
		end
		if (cmd.op == OP_STEP) begin
			step_q <= sprod[2*PITCH_W-1:32-FRAC_BITS];
		end
		if (cmd.op == OP_OUT) begin
			md_q <= zero_q ? {{(OUT_DATA_W-SAMPLE_BITS-1){1'b0}}, alive_q, {SAMPLE_BITS{1'b0}}}
			               : {{(OUT_DATA_W-SAMPLE_BITS-2){1'b0}}, xf_q, alive_q, s_q};
		end
	end

endmodule

>>> src/looping_sampler_voice.sv
// ----------------------------------------------------------------------------
// looping_sampler_voice
// Mono sampler voice with a crossfaded sustain loop, built as a sequencer
// driving a datapath around a single-port sample RAM.
// ----------------------------------------------------------------------------
// Write and restart items pass through a single state and return to idle. A tick on
// a dead voice goes straight to the result, and one that ends at its start skips the
// reads; a full tick's length is set by up to four reads of the one RAM port and the
// arithmetic steps, plus any wait on the result port. One item at a time.
// Reset clears position, loop state and configuration (base pitch to unity),
// sets the voice alive, and leaves the sample RAM as it is.
module looping_sampler_voice import lsv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// addr[19:0], sample_value[35:20], sustain[36], pitch_bend[54:37], zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// func[1:0]
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// sample_out[15:0], alive[16], in_crossfade[17], zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t  cmd;
	stat_t st;

	assign cfg_ready = 1'b1;

	lsv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.func     (s_tuser),
		.st       (st),
		.cmd      (cmd)
	);

	lsv_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// A result is only loaded when the output register is free.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUT) |-> st.out_free)
		else $error("result loaded over a waiting result");

	// The blend step always follows the second read.
	a_mix_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_FMIX) |-> ($past(cmd.op) == OP_FRD2))
		else $error("blend without its second read");

	// Nothing is worked on while a new request may be taken.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (cmd.op == OP_NONE))
		else $error("datapath busy while accepting");

endmodule

>>> dv/looping_sampler_voice_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// looping_sampler_voice_tb
// Drives sample writes, restarts and play ticks into the sampler voice under
// a series of loop and crossfade settings, with random gaps on both streams,
// and checks every returned sample against a cycle-free model of the voice.
// ----------------------------------------------------------------------------
module looping_sampler_voice_tb;
	import lsv_pkg::*;

	localparam logic [1:0] FN_IGNORED = 2'd3;
	localparam longint     MEM_TOP    = 64'd1 << ADDR_BITS;
	localparam longint     HI_BASE    = MEM_TOP - 64;
	localparam longint     POS_MAX    = (64'd1 << POS_W) - 1;
	localparam int         IDLE_PCT   = 28;

	class sample_tracker;
		typedef struct {
			logic signed [SAMPLE_BITS-1:0] smp;
			bit                            alive;
			bit                            xf;
		} voice_out_t;

		voice_out_t                    expected_out[$];
		logic signed [SAMPLE_BITS-1:0] sample_mem[longint];
		longint pos;
		bit     xf_on;
		bit     voice_on;
		longint end_smp, loop_start, loop_end, xf_len, xf_recip, loop_en, base_pitch;
		int     errors, n_write, n_restart, n_tick, n_xf, n_dead;

		function new();
			pos = 0; xf_on = 0; voice_on = 1;
			end_smp = 0; loop_start = 0; loop_end = 0; xf_len = 0;
			xf_recip = 0; loop_en = 0; base_pitch = 65536;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, longint val);
			case (idx)
				REG_END_SAMPLE: end_smp    = val & 64'h1FFFFF;
				REG_LOOP_START: loop_start = val & 64'hFFFFF;
				REG_LOOP_END:   loop_end   = val & 64'h1FFFFF;
				REG_XF_LEN:     xf_len     = val & 64'hFFFFF;
				REG_XF_RECIP:   xf_recip   = val & 64'h1FFFF;
				REG_LOOP_EN:    loop_en    = val & 1;
				REG_BASE_PITCH: base_pitch = val & 64'h3FFFF;
				default: ;
			endcase
		endfunction

		function longint rd(longint idx);
			if (idx >= MEM_TOP || !sample_mem.exists(idx))
				return 0;
			return longint'(sample_mem[idx]);
		endfunction

		function longint xf_start();
			return xf_len > loop_end ? 0 : loop_end - xf_len;
		endfunction

		// Blend of the loop head and the loop tail at offset j of the region.
		function longint blend_at(longint j);
			longint a, b, w;
			if (j >= xf_len)
				return rd(loop_start + j);
			a = rd(loop_start + j);
			b = rd(xf_start() + j);
			w = j * xf_recip;
			if (w > 65536)
				w = 65536;
			return (a * w + b * (65536 - w) + 32768) >>> 16;
		endfunction

		function bit beyond_end(bit looping);
			return !looping && !xf_on && pos >= (end_smp << FRAC_BITS);
		endfunction

		function void push(longint s, bit al, bit x);
			voice_out_t o;
			o.smp = s[SAMPLE_BITS-1:0]; o.alive = al; o.xf = x;
			expected_out.push_back(o);
			n_tick++;
			if (x) n_xf++;
			if (!al) n_dead++;
		endfunction

		function void play_tick(bit sus, longint bend);
			longint xs, i, f, a, b, s, np;
			bit     looping, in_xf;
			looping = sus && loop_en;
			if (!voice_on) begin
				push(0, 0, 0);
				return;
			end
			xs = xf_start();
			if (!xf_on && looping && pos >= (xs << FRAC_BITS)) begin
				xf_on = 1;
				pos -= xs << FRAC_BITS;
			end
			if (xf_on && pos >= (xf_len << FRAC_BITS)) begin
				xf_on = 0;
				np = pos - (xf_len << FRAC_BITS) + ((loop_start + xf_len) << FRAC_BITS);
				pos = np > POS_MAX ? POS_MAX : np;
			end
			if (beyond_end(looping)) begin
				voice_on = 0;
				push(0, 0, 0);
				return;
			end
			i = pos >> FRAC_BITS;
			f = pos & ((64'd1 << FRAC_BITS) - 1);
			in_xf = xf_on;
			if (in_xf) begin
				a = blend_at(i);
				b = blend_at(i + 1);
			end else begin
				a = rd(i);
				// The sample before the region leans on the first blended value.
				if (looping && i + 1 == xs)
					b = blend_at(0);
				else if (!looping && i + 1 >= end_smp)
					b = 0;
				else
					b = rd(i + 1);
			end
			s = (a * ((64'd1 << FRAC_BITS) - f) + b * f + (64'd1 << (FRAC_BITS - 1)))
				>>> FRAC_BITS;
			np = pos + ((base_pitch * bend) >> (32 - FRAC_BITS));
			if (np > POS_MAX) begin
				pos = POS_MAX;
				if (!looping && !xf_on)
					voice_on = 0;
			end else begin
				pos = np;
			end
			if (beyond_end(looping))
				voice_on = 0;
			push(s, voice_on, in_xf);
		endfunction

		function void accept_request(logic [1:0] fn, longint addr, logic [15:0] val,
				bit sus, longint bend);
			case (fn)
				FN_WRITE: begin
					sample_mem[addr] = val;
					n_write++;
				end
				FN_RESTART: begin
					pos = addr << FRAC_BITS;
					xf_on = 0;
					voice_on = 1;
					n_restart++;
				end
				FN_TICK: play_tick(sus, bend);
				default: ;
			endcase
		endfunction

		task report(string field, longint got, longint want);
			$display("mismatch in %s at %0t: got %0d, expected %0d", field, $realtime, got,
				want);
			errors++;
		endtask

		task check_sample(logic [OUT_DATA_W-1:0] data);
			voice_out_t o;
			if (expected_out.size() == 0) begin
				report("unexpected sample", longint'(data), 0);
				return;
			end
			o = expected_out.pop_front();
			if (data[15:0] !== o.smp)
				report("sample_out", longint'($signed(data[15:0])), longint'(o.smp));
			if (data[16] !== o.alive)
				report("alive", data[16], o.alive);
			if (data[17] !== o.xf)
				report("in_crossfade", data[17], o.xf);
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]            s_tuser = FN_WRITE;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_END_SAMPLE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	sample_tracker voice = new();
	bit            steady = 1'b0;
	bit            held = 1'b0;

	looping_sampler_voice uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	// Values read here are those from before the edge, so both sides see the
	// same handshake as the block.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			voice.check_sample(m_tdata);
		if (s_tvalid && s_tready)
			voice.accept_request(s_tuser, s_tdata[19:0], s_tdata[35:20], s_tdata[36],
				s_tdata[54:37]);
	end

	task automatic send(logic [1:0] fn, longint addr, logic [15:0] val, bit sus,
			longint bend);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= {1'b0, bend[17:0], sus, val, addr[19:0]};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic tick(bit sus, longint bend);
		send(FN_TICK, $urandom_range(MEM_TOP - 1), 16'($urandom), sus, bend);
	endtask

	// Waits until the block has nothing left in hand before registers change.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (voice.expected_out.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		voice.set_reg(idx, val);
	endtask

	task automatic configure(longint end_s, longint ls, longint le, longint xl,
			longint rcp, longint en, longint bp);
		drain();
		write_reg(REG_END_SAMPLE, end_s);
		write_reg(REG_LOOP_START, ls);
		write_reg(REG_LOOP_END, le);
		write_reg(REG_XF_LEN, xl);
		write_reg(REG_XF_RECIP, rcp);
		write_reg(REG_LOOP_EN, en);
		write_reg(REG_BASE_PITCH, bp);
		cfg_valid <= 1'b0;
	endtask

	// Low settings keep every read below 128; high ones keep it in the top
	// 64 entries or past the end of memory, both of which are filled first.
	task automatic random_settings(bit hi);
		longint le, ls, xl;
		if (hi) begin
			xl = ($urandom_range(3) == 0) ? 64'hFFFFF : $urandom_range(16);
			configure(MEM_TOP - $urandom_range(64), MEM_TOP - 1 - $urandom_range(63),
				MEM_TOP - $urandom_range(40), xl, $urandom_range(131071),
				$urandom_range(1), $urandom_range(262143));
		end else begin
			le = $urandom_range(40);
			ls = $urandom_range(le);
			xl = $urandom_range(le - ls);
			configure($urandom_range(40), ls, le, xl,
				($urandom_range(1) && xl != 0) ? 65536 / xl : $urandom_range(131071),
				$urandom_range(3) != 0, $urandom_range(65536, 16384));
		end
	endtask

	task automatic random_run(int n, bit hi);
		int     k, r;
		longint a;
		send(FN_RESTART, hi ? HI_BASE + $urandom_range(63) : $urandom_range(63), 0, 0, 0);
		held = 1'b1;
		k = 0;
		while (k < n) begin
			r = $urandom_range(99);
			if (r < 3) begin
				send(FN_IGNORED, $urandom, 16'($urandom), 1'($urandom_range(1)), $urandom);
				continue;
			end
			if (r < 16) begin
				a = hi ? HI_BASE + $urandom_range(63) : $urandom_range(127);
				send(FN_WRITE, a, 16'($urandom), 1'($urandom_range(1)), $urandom);
			end else if (r < 23) begin
				a = hi ? HI_BASE + $urandom_range(63) : $urandom_range(63);
				send(FN_RESTART, a, 16'($urandom), 1'($urandom_range(1)), $urandom);
			end else begin
				if ($urandom_range(19) == 0)
					held = !held;
				tick(held, hi ? $urandom_range(262143) : $urandom_range(131072));
			end
			k++;
		end
	endtask

	initial begin
		int p;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Fill both regions that playback is allowed to reach.
		for (longint a = 0; a < 128; a++)
			send(FN_WRITE, a, 16'($urandom), 0, 0);
		for (longint a = HI_BASE; a < MEM_TOP; a++)
			send(FN_WRITE, a, 16'($urandom), 0, 0);

		// Plain loop: cross the loop edge, play the region, leave it, release.
		configure(40, 8, 32, 8, 8192, 1, 65536);
		send(FN_WRITE, 0, 16'sh8000, 0, 0);
		send(FN_WRITE, 1, 16'sh7FFF, 1, 262143);
		send(FN_IGNORED, MEM_TOP - 1, 16'hFFFF, 1, 262143);
		send(FN_RESTART, 0, 0, 0, 0);
		tick(0, 65536);
		tick(0, 32768);
		send(FN_RESTART, 22, 0, 1, 0);
		repeat (10) tick(1, 98304);
		repeat (8) tick(0, 262143);

		// Crossfade longer than the loop: its start pins at zero.
		configure(40, 0, 8, 12, 131071, 1, 65536);
		send(FN_RESTART, 0, 0, 0, 0);
		repeat (16) tick(1, 65536);

		// Top of memory, fastest pitch, position runs into its ceiling.
		configure(MEM_TOP, MEM_TOP - 1, MEM_TOP, 0, 65536, 1, 262143);
		send(FN_RESTART, HI_BASE, 0, 0, 0);
		repeat (4) tick(1, 262143);
		repeat (3) tick(0, 262143);
		send(FN_RESTART, MEM_TOP - 2, 0, 0, 0);
		repeat (3) tick(0, 0);

		// Huge crossfade whose head lies past the end of memory.
		configure(MEM_TOP, MEM_TOP - 64, 500000, 64'hFFFFF, 131071, 1, 70000);
		send(FN_RESTART, MEM_TOP - 30, 0, 0, 0);
		repeat (5) tick(1, 65536);
		repeat (2) tick(0, 65536);

		// Everything zero: the voice is finished at once.
		configure(0, 0, 0, 0, 0, 0, 0);
		send(FN_RESTART, 5, 0, 0, 0);
		repeat (2) tick(1, 65536);
		send(FN_RESTART, 0, 0, 0, 0);
		tick(0, 262143);

		for (p = 0; p < 8; p++) begin
			random_settings(p[0]);
			steady = (p == 3);
			random_run(50, p[0]);
		end
		steady = 1'b0;

		drain();
		$display("Ran %0d writes, %0d restarts and %0d ticks over 13 settings;",
			voice.n_write, voice.n_restart, voice.n_tick);
		$display("%0d samples came from the crossfade, %0d from a finished voice.",
			voice.n_xf, voice.n_dead);
		if (voice.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
